// ===== sv/crcfd_pkg.sv =====
package crcfd_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned CRC_W       = 16;
   localparam int unsigned LEN_W       = 16;
   localparam int unsigned FLEN_W      = 10;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam int unsigned MAX_PAYLOAD_DEFAULT = 512;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_START = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_START  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_END   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_END    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CRC_POLY    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CRC_INIT    = 3'd5;

   // register reset values
   localparam logic [BYTE_W-1:0] SHORT_START_RESET = 8'h02;
   localparam logic [BYTE_W-1:0] LONG_START_RESET  = 8'h03;
   localparam logic [BYTE_W-1:0] SHORT_END_RESET   = 8'h03;
   localparam logic [BYTE_W-1:0] LONG_END_RESET    = 8'h03;
   localparam logic [CRC_W-1:0]  CRC_POLY_RESET    = 16'h1021;
   localparam logic [CRC_W-1:0]  CRC_INIT_RESET    = 16'h0000;

   localparam logic OUT_PAYLOAD = 1'b0;
   localparam logic OUT_VERDICT = 1'b1;

   typedef enum logic [1:0] {
      VERDICT_OK      = 2'd0,
      VERDICT_BAD_LEN = 2'd1,
      VERDICT_BAD_END = 2'd2,
      VERDICT_BAD_CRC = 2'd3
   } verdict_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_LEN1  = 3'd1,
      PH_LENHI = 3'd2,
      PH_LENLO = 3'd3,
      PH_DATA  = 3'd4,
      PH_CRCHI = 3'd5,
      PH_CRCLO = 3'd6,
      PH_END   = 3'd7
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] short_start;
      logic [BYTE_W-1:0] long_start;
      logic [BYTE_W-1:0] short_end;
      logic [BYTE_W-1:0] long_end;
      logic [CRC_W-1:0]  crc_poly;
      logic [CRC_W-1:0]  crc_init;
   } cfg_type;

   // msb-first crc16 over one byte, no reflection
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0]  crc,
                                                 input logic [BYTE_W-1:0] data,
                                                 input logic [CRC_W-1:0]  poly);
      logic [CRC_W-1:0] c;
      c = crc ^ {data, {(CRC_W-BYTE_W){1'b0}}};
      for (int i = 0; i < BYTE_W; i++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ poly;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== sv/crc_framed_packet_deframer.sv =====
// a result is in the output register in the cycle after its byte beat is taken
// throughput: one byte beat per cycle while the rsp side keeps up; the frame state machine and the bytewise
//   crc16 update both sit between the input handshake and the result register
// req_ready drops only while a result waits unclaimed on a stalled rsp side
// reset (synchronous): frame state to idle, output empty, registers to defaults
module crc_framed_packet_deframer #(
   parameter int unsigned MAX_PAYLOAD = crcfd_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // byte input
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [crcfd_pkg::BYTE_W-1:0]          req_rx_byte,
   // result output
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_out_kind,
   output logic [crcfd_pkg::BYTE_W-1:0]          rsp_payload_byte,
   output logic [1:0]                            rsp_verdict,
   output logic [crcfd_pkg::FLEN_W-1:0]          rsp_frame_length,
   output logic                                  rsp_long_frame,
   output logic [crcfd_pkg::CRC_W-1:0]           rsp_computed_crc,
   output logic [crcfd_pkg::CRC_W-1:0]           rsp_received_crc,
   // register writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [crcfd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [crcfd_pkg::CSR_DATA_W-1:0]      csr_data
);

   // payload counter only has to reach the largest legal length
   localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);
   localparam int unsigned LEN_W = crcfd_pkg::LEN_W;
   localparam int unsigned CRC_W = crcfd_pkg::CRC_W;
   localparam int unsigned BYTE_W = crcfd_pkg::BYTE_W;
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

   crcfd_pkg::cfg_type cfg;

   // register bank, always ready
   assign csr_ready = 1'b1;

   crcfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // frame state
   crcfd_pkg::phase_type phase_ff, phase_in;
   logic                 long_mode_ff, long_mode_in;
   logic [LEN_W-1:0]     expected_ff, expected_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CRC_W-1:0]     frame_crc_ff, frame_crc_in;
   logic [CRC_W-1:0]     running_crc_ff, running_crc_in;

   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           out_kind_ff, out_kind_in;
   logic [BYTE_W-1:0]              payload_ff, payload_in;
   crcfd_pkg::verdict_type         verdict_ff, verdict_in;
   logic [crcfd_pkg::FLEN_W-1:0]   flen_ff, flen_in;
   logic                           long_frame_ff, long_frame_in;
   logic [CRC_W-1:0]               comp_crc_ff, comp_crc_in;
   logic [CRC_W-1:0]               recv_crc_ff, recv_crc_in;

   logic               req_fire;
   logic               rsp_fire;
   logic               emit;
   logic [LEN_W-1:0]   len_cand;
   logic [CNT_W-1:0]   count_inc;
   logic [CRC_W-1:0]   crc_next;
   logic [BYTE_W-1:0]  end_want;

   // the output register frees up in the same cycle its beat is taken
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;

   assign count_inc = count_ff + CNT_W'(1);
   assign crc_next  = crcfd_pkg::crc_byte(running_crc_ff, req_rx_byte, cfg.crc_poly);
   assign end_want  = long_mode_ff ? cfg.long_end : cfg.short_end;

   // length byte as it lands: short form takes it whole, long form fills the low half
   assign len_cand = (phase_ff == crcfd_pkg::PH_LEN1)
                     ? {{(LEN_W-BYTE_W){1'b0}}, req_rx_byte}
                     : {expected_ff[LEN_W-1:BYTE_W], req_rx_byte};

   always_comb begin
      phase_in       = phase_ff;
      long_mode_in   = long_mode_ff;
      expected_in    = expected_ff;
      count_in       = count_ff;
      frame_crc_in   = frame_crc_ff;
      running_crc_in = running_crc_ff;

      emit          = 1'b0;
      out_kind_in   = crcfd_pkg::OUT_PAYLOAD;
      payload_in    = '0;
      verdict_in    = crcfd_pkg::VERDICT_OK;
      flen_in       = '0;
      long_frame_in = 1'b0;
      comp_crc_in   = '0;
      recv_crc_in   = '0;

      if (req_fire) begin
         case (phase_ff)
            crcfd_pkg::PH_IDLE: begin
               // short start wins when both start values match
               if (req_rx_byte == cfg.short_start || req_rx_byte == cfg.long_start) begin
                  long_mode_in   = (req_rx_byte != cfg.short_start);
                  expected_in    = '0;
                  count_in       = '0;
                  frame_crc_in   = '0;
                  running_crc_in = cfg.crc_init;
                  phase_in       = (req_rx_byte != cfg.short_start)
                                   ? crcfd_pkg::PH_LENHI : crcfd_pkg::PH_LEN1;
               end
            end
            crcfd_pkg::PH_LEN1,
            crcfd_pkg::PH_LENLO: begin
               if (len_cand == '0 || len_cand > MAX_LEN) begin
                  // rejected length, report and drop back to idle
                  emit           = 1'b1;
                  out_kind_in    = crcfd_pkg::OUT_VERDICT;
                  verdict_in     = crcfd_pkg::VERDICT_BAD_LEN;
                  long_frame_in  = long_mode_ff;
                  phase_in       = crcfd_pkg::PH_IDLE;
                  long_mode_in   = 1'b0;
                  expected_in    = '0;
                  count_in       = '0;
                  frame_crc_in   = '0;
                  running_crc_in = cfg.crc_init;
               end else begin
                  expected_in = len_cand;
                  count_in    = '0;
                  phase_in    = crcfd_pkg::PH_DATA;
               end
            end
            crcfd_pkg::PH_LENHI: begin
               expected_in = {req_rx_byte, {(LEN_W-BYTE_W){1'b0}}};
               phase_in    = crcfd_pkg::PH_LENLO;
            end
            crcfd_pkg::PH_DATA: begin
               // tentative payload beat, crc folded in as it passes
               running_crc_in = crc_next;
               count_in       = count_inc;
               if (LEN_W'(count_inc) >= expected_ff) begin
                  phase_in = crcfd_pkg::PH_CRCHI;
               end
               emit       = 1'b1;
               payload_in = req_rx_byte;
            end
            crcfd_pkg::PH_CRCHI: begin
               frame_crc_in = {req_rx_byte, {(CRC_W-BYTE_W){1'b0}}};
               phase_in     = crcfd_pkg::PH_CRCLO;
            end
            crcfd_pkg::PH_CRCLO: begin
               frame_crc_in = {frame_crc_ff[CRC_W-1:BYTE_W], req_rx_byte};
               phase_in     = crcfd_pkg::PH_END;
            end
            crcfd_pkg::PH_END: begin
               // bad end byte outranks a crc mismatch
               emit          = 1'b1;
               out_kind_in   = crcfd_pkg::OUT_VERDICT;
               if (req_rx_byte != end_want) begin
                  verdict_in = crcfd_pkg::VERDICT_BAD_END;
               end else if (running_crc_ff != frame_crc_ff) begin
                  verdict_in = crcfd_pkg::VERDICT_BAD_CRC;
               end else begin
                  verdict_in = crcfd_pkg::VERDICT_OK;
               end
               flen_in        = expected_ff[crcfd_pkg::FLEN_W-1:0];
               long_frame_in  = long_mode_ff;
               comp_crc_in    = running_crc_ff;
               recv_crc_in    = frame_crc_ff;
               phase_in       = crcfd_pkg::PH_IDLE;
               long_mode_in   = 1'b0;
               expected_in    = '0;
               count_in       = '0;
               frame_crc_in   = '0;
               running_crc_in = cfg.crc_init;
            end
            default: begin
               phase_in = crcfd_pkg::PH_IDLE;
            end
         endcase
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= crcfd_pkg::PH_IDLE;
         long_mode_ff   <= 1'b0;
         expected_ff    <= '0;
         count_ff       <= '0;
         frame_crc_ff   <= '0;
         running_crc_ff <= crcfd_pkg::CRC_INIT_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         long_mode_ff   <= long_mode_in;
         expected_ff    <= expected_in;
         count_ff       <= count_in;
         frame_crc_ff   <= frame_crc_in;
         running_crc_ff <= running_crc_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // result payload, loaded only when a new beat is produced
   always_ff @(posedge clock) begin
      if (emit) begin
         out_kind_ff   <= out_kind_in;
         payload_ff    <= payload_in;
         verdict_ff    <= verdict_in;
         flen_ff       <= flen_in;
         long_frame_ff <= long_frame_in;
         comp_crc_ff   <= comp_crc_in;
         recv_crc_ff   <= recv_crc_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_kind     = out_kind_ff;
   assign rsp_payload_byte = payload_ff;
   assign rsp_verdict      = verdict_ff;
   assign rsp_frame_length = flen_ff;
   assign rsp_long_frame   = long_frame_ff;
   assign rsp_computed_crc = comp_crc_ff;
   assign rsp_received_crc = recv_crc_ff;

   // a payload byte taken in the data phase shows up as the next result beat
   a_payload_passes: assert property (@(posedge clock) disable iff (reset)
      (req_fire && phase_ff == crcfd_pkg::PH_DATA) |=>
      (rsp_valid && rsp_out_kind == crcfd_pkg::OUT_PAYLOAD &&
       rsp_payload_byte == $past(req_rx_byte)))
      else $error("payload beat lost or corrupted");

   // the counter never runs past the announced length
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == crcfd_pkg::PH_DATA) |-> (LEN_W'(count_ff) < expected_ff))
      else $error("payload count overran frame length");

   // an ok verdict always carries matching crcs
   a_ok_crc_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_kind == crcfd_pkg::OUT_VERDICT &&
       rsp_verdict == crcfd_pkg::VERDICT_OK) |-> (rsp_computed_crc == rsp_received_crc))
      else $error("ok verdict with differing crcs");

   // idle bytes, high length bytes and crc bytes never create a result
   a_quiet_header: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !rsp_fire && rsp_valid_ff == 1'b0 &&
       (phase_ff == crcfd_pkg::PH_IDLE || phase_ff == crcfd_pkg::PH_LENHI ||
        phase_ff == crcfd_pkg::PH_CRCHI || phase_ff == crcfd_pkg::PH_CRCLO))
      |=> !rsp_valid)
      else $error("result produced from a header byte");

endmodule

// ===== sv/crcfd_csr.sv =====
module crcfd_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [crcfd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [crcfd_pkg::CSR_DATA_W-1:0]      csr_data,
   output crcfd_pkg::cfg_type                    cfg
);

   crcfd_pkg::cfg_type cfg_ff;
   crcfd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            crcfd_pkg::CSR_SHORT_START: cfg_in.short_start = csr_data[crcfd_pkg::BYTE_W-1:0];
            crcfd_pkg::CSR_LONG_START:  cfg_in.long_start  = csr_data[crcfd_pkg::BYTE_W-1:0];
            crcfd_pkg::CSR_SHORT_END:   cfg_in.short_end   = csr_data[crcfd_pkg::BYTE_W-1:0];
            crcfd_pkg::CSR_LONG_END:    cfg_in.long_end    = csr_data[crcfd_pkg::BYTE_W-1:0];
            crcfd_pkg::CSR_CRC_POLY:    cfg_in.crc_poly    = csr_data[crcfd_pkg::CRC_W-1:0];
            crcfd_pkg::CSR_CRC_INIT:    cfg_in.crc_init    = csr_data[crcfd_pkg::CRC_W-1:0];
            default: ; // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_start <= crcfd_pkg::SHORT_START_RESET;
         cfg_ff.long_start  <= crcfd_pkg::LONG_START_RESET;
         cfg_ff.short_end   <= crcfd_pkg::SHORT_END_RESET;
         cfg_ff.long_end    <= crcfd_pkg::LONG_END_RESET;
         cfg_ff.crc_poly    <= crcfd_pkg::CRC_POLY_RESET;
         cfg_ff.crc_init    <= crcfd_pkg::CRC_INIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
